// File: rtl/core/htd_pkg.sv
// Shared types and constants for the Huffman tree-walk decoder.
// No dependencies; imported by htd_node_mem and huffman_tree_decoder_core.
`default_nettype none

package htd_pkg;

	// Table size and field widths
	localparam int NODE_COUNT = 512;
	localparam int ADDR_W     = $clog2(NODE_COUNT);
	localparam int IDX_W      = 9;
	localparam int SYM_W      = 8;
	localparam int CODE_W     = 8;
	localparam int BITS_W     = $clog2(CODE_W + 1);

	// Stream packing
	localparam int IN_FIELDS_W = 3 * IDX_W + 1 + SYM_W + CODE_W;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = SYM_W;

	// Request kinds carried on tuser
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	typedef struct packed {
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic             leaf;
		logic [SYM_W-1:0] sym;
	} node_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} htd_state_t;

endpackage

`default_nettype wire

// File: rtl/core/huffman_tree_decoder_core.sv
// Top level of the Huffman tree-walk decoder: request handshake, walk sequencer, output stage.
// Depends on htd_pkg and htd_node_mem.
`default_nettype none

// Huffman tree-walk decoder. A load request (tuser = 0) writes one node of the
// table (children, leaf flag, symbol). A decode request (tuser = 1) carries one
// coded byte; its bits are shifted out most significant first, one per cycle
// while no leaf is being handled, each bit steering the walk to the left (0)
// or right (1) child through a node-table read. When a leaf is reached its
// symbol is queued and the walk restarts at the root by refetching the root
// node; the restart waits while the output is stalled with a symbol held. A
// decode request holds the block until its bits are walked and its last symbol,
// if any, is in the output register. The single read port of the node memory,
// used once per bit and once per restart, paces the walk. Results leave through
// an output register on the m_axis side, tlast marking the final symbol of each
// byte; a byte that reaches no leaf produces nothing. The walk position carries
// over between bytes. Writing root_node (cfg_we) also resets the walk to the
// root; write it only while the block is idle. The node table has no reset:
// walking into a node that was never loaded gives undefined symbols.
module huffman_tree_decoder_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration: root node index
	input  wire logic                         cfg_we,
	input  wire logic [htd_pkg::IDX_W-1:0]    cfg_wdata,
	// request stream
	input  wire logic                         s_axis_tvalid,
	output      logic                         s_axis_tready,
	// tdata, low bit up: node_index[9], left_child[9], right_child[9],
	// is_leaf[1], leaf_symbol[8], coded_byte[8], zero pad[4]
	input  wire logic [htd_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// tuser: command (0 = load node, 1 = decode byte)
	input  wire logic                         s_axis_tuser,
	// result stream
	output      logic                         m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	// tdata: symbol[8]
	output      logic [htd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output      logic                         m_axis_tlast
);
	import htd_pkg::*;

	// Request field unpacking
	logic [IDX_W-1:0]  in_node_index;
	logic [IDX_W-1:0]  in_left;
	logic [IDX_W-1:0]  in_right;
	logic              in_leaf;
	logic [SYM_W-1:0]  in_sym;
	logic [CODE_W-1:0] in_code;

	assign in_node_index = s_axis_tdata[IDX_W-1:0];
	assign in_left       = s_axis_tdata[2*IDX_W-1:IDX_W];
	assign in_right      = s_axis_tdata[3*IDX_W-1:2*IDX_W];
	assign in_leaf       = s_axis_tdata[3*IDX_W];
	assign in_sym        = s_axis_tdata[3*IDX_W+SYM_W:3*IDX_W+1];
	assign in_code       = s_axis_tdata[3*IDX_W+SYM_W+CODE_W:3*IDX_W+SYM_W+1];

	// State
	htd_state_t        state_q, state_d;
	logic [IDX_W-1:0]  root_q;
	logic [IDX_W-1:0]  pos_q;
	logic [CODE_W-1:0] shift_q;      // code bits still to walk, next one at the top
	logic [BITS_W-1:0] bits_q;       // count of code bits still to walk
	logic              check_q;      // node on the read port was reached by a bit
	logic              pend_valid_q; // one symbol held back until its tlast is known
	logic [SYM_W-1:0]  pend_sym_q;
	logic              out_valid_q;
	logic [SYM_W-1:0]  out_sym_q;
	logic              out_last_q;

	// Node memory
	node_t             cur_node;
	node_t             wr_node;
	logic              mem_wr_en;
	logic              mem_rd_en;
	logic [IDX_W-1:0]  mem_rd_idx;

	assign wr_node = '{left: in_left, right: in_right, leaf: in_leaf, sym: in_sym};

	htd_node_mem u_node_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_idx  (in_node_index),
		.wr_node (wr_node),
		.rd_en   (mem_rd_en),
		.rd_idx  (mem_rd_idx),
		.rd_node (cur_node)
	);

	// Control decode
	logic              in_acc;
	logic              leaf_hit;
	logic              out_free;
	logic              step_leaf;
	logic              step_bit;
	logic              step_end;
	logic              push;
	logic [IDX_W-1:0]  child_idx;

	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		in_acc        = s_axis_tvalid && s_axis_tready;
		out_free      = !out_valid_q || m_axis_tready;
		leaf_hit      = check_q && cur_node.leaf;
		child_idx     = shift_q[CODE_W-1] ? cur_node.right : cur_node.left;

		// leaf reached: queue its symbol, hand the older one to the output
		step_leaf = (state_q == ST_WALK) && leaf_hit && (!pend_valid_q || out_free);
		// walk one code bit
		step_bit  = (state_q == ST_WALK) && !leaf_hit && (bits_q != '0);
		// byte exhausted: flush the held symbol as the last one
		step_end  = (state_q == ST_WALK) && !leaf_hit && (bits_q == '0)
			&& (!pend_valid_q || out_free);
		push      = (step_leaf || step_end) && pend_valid_q;

		mem_wr_en  = in_acc && (s_axis_tuser == CMD_LOAD);
		mem_rd_en  = (in_acc && (s_axis_tuser == CMD_DECODE)) || step_leaf || step_bit;
		if (step_leaf) begin
			mem_rd_idx = root_q;
		end else if (step_bit) begin
			mem_rd_idx = child_idx;
		end else begin
			mem_rd_idx = pos_q;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && (s_axis_tuser == CMD_DECODE)) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (step_end) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			root_q       <= '0;
			pos_q        <= '0;
			bits_q       <= '0;
			check_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				root_q <= cfg_wdata;
				pos_q  <= cfg_wdata;
			end else if (step_leaf) begin
				pos_q <= root_q;
			end else if (step_bit) begin
				pos_q <= child_idx;
			end

			// start a byte: the root-or-carried node is fetched, not tested
			if (in_acc && (s_axis_tuser == CMD_DECODE)) begin
				bits_q  <= BITS_W'(CODE_W);
				check_q <= 1'b0;
			end else if (step_bit) begin
				bits_q  <= bits_q - 1'b1;
				check_q <= 1'b1;
			end else if (step_leaf) begin
				check_q <= 1'b0;
			end

			if (step_leaf) begin
				pend_valid_q <= 1'b1;
			end else if (step_end) begin
				pend_valid_q <= 1'b0;
			end

			if (push) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc && (s_axis_tuser == CMD_DECODE)) begin
			shift_q <= in_code;
		end else if (step_bit) begin
			shift_q <= {shift_q[CODE_W-2:0], 1'b0};
		end
		if (step_leaf) begin
			pend_sym_q <= cur_node.sym;
		end
		if (push) begin
			out_sym_q  <= pend_sym_q;
			out_last_q <= step_end;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_sym_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_pend_only_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (state_q == ST_WALK))
		else $error("held symbol outside a byte walk");

	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		(bits_q <= BITS_W'(CODE_W)))
		else $error("bit counter beyond byte width");

	a_decode_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_DECODE))
		|=> ((state_q == ST_WALK) && (bits_q == BITS_W'(CODE_W)) && !check_q))
		else $error("decode request did not start a full byte walk");

	a_end_all_bits: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WALK) && (state_d == ST_IDLE)) |-> (bits_q == '0))
		else $error("walk ended with code bits left");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("output register overwritten while stalled");
`endif

endmodule

`default_nettype wire

// File: rtl/core/htd_node_mem.sv
// Node table of the tree-walk decoder: one write port, one registered read port.
// Depends on htd_pkg for node_t and the table size.
`default_nettype none

module htd_node_mem (
	input  wire logic                    clk,
	input  wire logic                    wr_en,
	input  wire logic [htd_pkg::IDX_W-1:0] wr_idx,
	input  wire htd_pkg::node_t          wr_node,
	input  wire logic                    rd_en,
	input  wire logic [htd_pkg::IDX_W-1:0] rd_idx,
	output htd_pkg::node_t               rd_node
);
	import htd_pkg::*;

	node_t             mem [NODE_COUNT];
	node_t             rd_q;
	logic              rd_oor_q;
	logic              wr_in_range;
	logic              rd_in_range;

	assign wr_in_range = 32'(wr_idx) < NODE_COUNT;
	assign rd_in_range = 32'(rd_idx) < NODE_COUNT;

	// drop writes beyond the table
	always_ff @(posedge clk) begin
		if (wr_en && wr_in_range) begin
			mem[ADDR_W'(wr_idx)] <= wr_node;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q     <= mem[ADDR_W'(rd_idx)];
			rd_oor_q <= !rd_in_range;
		end
	end

	// an index beyond the table reads as an all-zero node
	assign rd_node = rd_oor_q ? '0 : rd_q;

endmodule

`default_nettype wire

// File: verif/huffman_tree_decoder_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for huffman_tree_decoder_core: loads node tables, decodes bytes
// and checks every symbol against its own tree walk. Depends on htd_pkg and the core RTL.

module huffman_tree_decoder_core_tb;
	import htd_pkg::*;

	// Request fields as they sit on s_axis_tdata, lowest field last in the list
	typedef struct packed {
		logic [IN_TDATA_W-IN_FIELDS_W-1:0] pad;
		logic [CODE_W-1:0]                 code;
		logic [SYM_W-1:0]                  sym;
		logic                              leaf;
		logic [IDX_W-1:0]                  right;
		logic [IDX_W-1:0]                  left;
		logic [IDX_W-1:0]                  idx;
	} req_fields_t;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             last;
	} sym_exp_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [IDX_W-1:0]       cfg_wdata;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;

	// Tree-walk predictor state
	node_t            node_tbl [NODE_COUNT];
	logic [IDX_W-1:0] walk_pos;
	logic [IDX_W-1:0] root_reg;
	sym_exp_t         expected_syms [$];
	sym_exp_t         want_sym;

	// Nodes of the tree currently under decode
	bit               in_tree [NODE_COUNT];
	logic [IDX_W-1:0] tree_nodes [$];

	int src_idle_pct   = 20;
	int sink_stall_pct = 20;
	bit hold_req       = 1'b0;
	int hold_req_len   = 0;
	int hold_left      = 0;

	int errors       = 0;
	int loads_sent   = 0;
	int bytes_sent   = 0;
	int roots_set    = 0;
	int syms_checked = 0;

	huffman_tree_decoder_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [IDX_W-1:0] rand_idx();
		return IDX_W'($urandom_range(NODE_COUNT - 1));
	endfunction

	function automatic logic [SYM_W-1:0] rand_sym();
		return SYM_W'($urandom_range(255));
	endfunction

	// Walk the code bits MSB first; queue one symbol per leaf reached
	function automatic void predict_symbols(input logic [CODE_W-1:0] code);
		logic [SYM_W-1:0] found [CODE_W];
		node_t cur;
		int n;
		n = 0;
		for (int b = CODE_W - 1; b >= 0; b--) begin
			cur = node_tbl[walk_pos];
			walk_pos = code[b] ? cur.right : cur.left;
			if (node_tbl[walk_pos].leaf) begin
				found[n] = node_tbl[walk_pos].sym;
				n++;
				walk_pos = root_reg;
			end
		end
		for (int i = 0; i < n; i++)
			expected_syms.push_back('{sym: found[i], last: (i == n - 1)});
	endfunction

	// Offer one request, idling at random first; update the predictor on acceptance
	task automatic send_req(input logic cmd, input req_fields_t f);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= f;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (cmd == CMD_LOAD) begin
			node_tbl[f.idx] = '{left: f.left, right: f.right, leaf: f.leaf, sym: f.sym};
			loads_sent++;
		end else begin
			predict_symbols(f.code);
			bytes_sent++;
		end
	endtask

	task automatic load_node(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] l,
			input logic [IDX_W-1:0] r, input logic leaf, input logic [SYM_W-1:0] sym);
		req_fields_t f;
		f = '{pad: '0, code: rand_sym(), sym: sym, leaf: leaf, right: r, left: l, idx: idx};
		send_req(CMD_LOAD, f);
	endtask

	// Fields other than the code byte carry noise the block must ignore
	task automatic decode_byte(input logic [CODE_W-1:0] code);
		req_fields_t f;
		f = '{pad: '0, code: code, sym: rand_sym(), leaf: 1'($urandom),
			right: rand_idx(), left: rand_idx(), idx: rand_idx()};
		send_req(CMD_DECODE, f);
	endtask

	// Drop valid, wait for every queued symbol, then let a walk in flight finish
	task automatic drain(input int settle);
		s_axis_tvalid <= 1'b0;
		while (expected_syms.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_root(input logic [IDX_W-1:0] idx);
		drain(24);
		cfg_we    <= 1'b1;
		cfg_wdata <= idx;
		@(posedge clk);
		cfg_we   <= 1'b0;
		root_reg = idx;
		walk_pos = idx;
		roots_set++;
	endtask

	function automatic logic [IDX_W-1:0] fresh_node();
		logic [IDX_W-1:0] p;
		do
			p = rand_idx();
		while (in_tree[p]);
		in_tree[p] = 1'b1;
		tree_nodes.push_back(p);
		return p;
	endfunction

	// Build a full binary tree bottom up; a chain gives one code per depth
	task automatic build_tree(input int leaves, input bit chain, output logic [IDX_W-1:0] top);
		logic [IDX_W-1:0] subtrees [$];
		logic [IDX_W-1:0] a, b, p;
		int k;
		in_tree = '{default: 1'b0};
		tree_nodes.delete();
		for (int i = 0; i < leaves; i++) begin
			p = fresh_node();
			load_node(p, rand_idx(), rand_idx(), 1'b1, rand_sym());
			subtrees.push_back(p);
		end
		while (subtrees.size() > 1) begin
			if (chain) begin
				a = subtrees.pop_back();
			end else begin
				k = $urandom_range(subtrees.size() - 1);
				a = subtrees[k];
				subtrees.delete(k);
			end
			k = $urandom_range(subtrees.size() - 1);
			b = subtrees[k];
			subtrees.delete(k);
			p = fresh_node();
			if ($urandom_range(1) == 1)
				load_node(p, a, b, 1'b0, rand_sym());
			else
				load_node(p, b, a, 1'b0, rand_sym());
			subtrees.push_back(p);
		end
		top = subtrees[0];
	endtask

	// Root 0 from reset; both children leaves, so each byte gives eight symbols
	task automatic test_reset_root();
		load_node(9'd1, 9'd0, 9'd0, 1'b1, 8'h00);
		load_node(9'd2, 9'd511, 9'd511, 1'b1, 8'hFF);
		load_node(9'd0, 9'd1, 9'd2, 1'b0, 8'h3C);
		decode_byte(8'h00);
		decode_byte(8'hFF);
		decode_byte(8'hA5);
		load_node(9'd400, 9'd511, 9'd0, 1'b0, 8'hFF);
		decode_byte(8'h5A);
	endtask

	// A leaf at the root is never emitted itself
	task automatic test_root_leaf();
		load_node(9'd511, 9'd1, 9'd2, 1'b1, 8'h77);
		write_root(9'd511);
		decode_byte(8'hC3);
	endtask

	// A self loop on the left: zero bits never reach a leaf, so a byte may give nothing
	task automatic test_no_leaf_byte();
		load_node(9'd300, 9'd300, 9'd2, 1'b0, 8'h11);
		write_root(9'd300);
		decode_byte(8'h00);
		decode_byte(8'h00);
		decode_byte(8'h01);
		decode_byte(8'h80);
		write_root(9'd0);
		decode_byte(8'h96);
	endtask

	// Codes longer than a byte; the walk position carries across bytes
	task automatic test_deep_codes();
		logic [IDX_W-1:0] top;
		build_tree(12, 1'b1, top);
		write_root(top);
		for (int i = 0; i < 10; i++)
			decode_byte(rand_sym());
	endtask

	// Random trees, mostly decodes, with symbol rewrites and loads off the tree
	task automatic test_random_trees();
		logic [IDX_W-1:0] top, n;
		int pick;
		for (int ph = 0; ph < 2; ph++) begin
			build_tree($urandom_range(2, 16), ($urandom_range(3) == 0), top);
			write_root(top);
			for (int i = 0; i < 20; i++) begin
				pick = $urandom_range(99);
				if (pick < 85) begin
					decode_byte(rand_sym());
				end else if (pick < 95) begin
					n = tree_nodes[$urandom_range(tree_nodes.size() - 1)];
					load_node(n, node_tbl[n].left, node_tbl[n].right, node_tbl[n].leaf,
						rand_sym());
				end else begin
					do
						n = rand_idx();
					while (in_tree[n]);
					load_node(n, rand_idx(), rand_idx(), 1'($urandom), rand_sym());
				end
			end
		end
	endtask

	// Full rate on both sides, then a long receiver hold so the input backs up
	task automatic test_backpressure();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		for (int i = 0; i < 15; i++)
			decode_byte(rand_sym());
		hold_req_len = 400;
		hold_req     = 1'b1;
		for (int i = 0; i < 10; i++)
			decode_byte(rand_sym());
		src_idle_pct   = 20;
		sink_stall_pct = 20;
	endtask

	// Receiver: random stalls, or a counted hold when one is requested
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = hold_req_len;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// Compare each accepted symbol with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_syms.size() == 0) begin
				$error("symbol %02h with no prediction waiting", m_axis_tdata);
				errors++;
			end else begin
				want_sym = expected_syms.pop_front();
				syms_checked++;
				if (m_axis_tdata !== want_sym.sym) begin
					$error("symbol: expected %02h, got %02h", want_sym.sym, m_axis_tdata);
					errors++;
				end
				if (m_axis_tlast !== want_sym.last) begin
					$error("last: expected %0b, got %0b", want_sym.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_LOAD;
		node_tbl      = '{default: '0};
		walk_pos      = '0;
		root_reg      = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_root();
		test_root_leaf();
		test_no_leaf_byte();
		test_deep_codes();
		test_random_trees();
		test_backpressure();
		drain(40);

		$display("Covered %0d node loads, %0d coded bytes and %0d root writes,",
			loads_sent, bytes_sent, roots_set);
		$display("with %0d decoded symbols compared under random and held back-pressure.",
			syms_checked);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/htd_pkg.sv
rtl/core/htd_node_mem.sv
rtl/core/huffman_tree_decoder_core.sv
verif/huffman_tree_decoder_core_tb.sv
